// ----- rtl/core/csort_pkg.sv -----
// ----------------------------------------------------------------------------
// csort_pkg
// Shared sizes, register codes, control types and helpers for the column sum
// sorter.
// ----------------------------------------------------------------------------
package csort_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int SIZE_W = 5;
  localparam int ELEM_W = 16;
  localparam int SUM_W  = 20;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
  localparam logic [SIZE_W-1:0] ROWS_LIMIT = SIZE_W'(MAX_ROWS);
  localparam logic [SIZE_W-1:0] COLS_LIMIT = SIZE_W'(MAX_COLS);

  // Register select, taken from paddr[2]
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic load;
    logic job_start;
    logic scan_step;
    logic emit_done;
  } csort_cmd_t;

  typedef struct packed {
    logic elem_last;
    logic scan_last;
    logic rank_last;
  } csort_status_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/csort_ctrl.sv -----
// ----------------------------------------------------------------------------
// csort_ctrl
// Sequencer for the sorter: load the matrix, scan for each rank, emit words.
// ----------------------------------------------------------------------------
module csort_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    out_stall,
  input  csort_pkg::csort_status_t status,
  output logic                    in_stall,
  output logic                    out_valid,
  output csort_pkg::csort_cmd_t   cmd
);
  import csort_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == ST_LOAD) && in_valid && !in_stall;
    cmd.job_start = cmd.load && status.elem_last;
    cmd.scan_step = (state == ST_SCAN);
    cmd.emit_done = (state == ST_EMIT) && out_valid && !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (cmd.job_start) begin
            state    <= ST_SCAN;
            in_stall <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (status.scan_last) begin
            state     <= ST_EMIT;
            out_valid <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (cmd.emit_done) begin
            out_valid <= 1'b0;
            if (status.rank_last) begin
              state    <= ST_LOAD;
              in_stall <= 1'b0;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        default: begin
          state     <= ST_LOAD;
          in_stall  <= 1'b0;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/csort_dp.sv -----
// ----------------------------------------------------------------------------
// csort_dp
// Column sum storage, load positions, max-search scan and the result register.
// ----------------------------------------------------------------------------
module csort_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  csort_pkg::csort_cmd_t                cmd,
  input  logic                                 cfg_clear,
  input  logic [csort_pkg::SIZE_W-1:0]         rows_eff,
  input  logic [csort_pkg::SIZE_W-1:0]         cols_eff,
  input  logic signed [csort_pkg::ELEM_W-1:0]  elem_value,
  output csort_pkg::csort_status_t             status,
  output logic [csort_pkg::COL_W-1:0]          source_column,
  output logic signed [csort_pkg::SUM_W-1:0]   column_sum,
  output logic                                 last_flag
);
  import csort_pkg::*;

  logic [ROW_W-1:0]        row_pos;
  logic [COL_W-1:0]        col_pos;
  logic [COL_W-1:0]        scan_idx;
  logic [COL_W-1:0]        rank_idx;
  logic [COL_W-1:0]        best_col;
  logic [COL_W-1:0]        final_col;
  logic signed [SUM_W-1:0] sum_mem [MAX_COLS];
  logic signed [SUM_W-1:0] rd_sum;
  logic signed [SUM_W-1:0] best_sum;
  logic signed [SUM_W-1:0] final_sum;
  logic signed [SUM_W-1:0] elem_ext;
  logic [MAX_COLS-1:0]     picked;
  logic                    has_best;
  logic                    take;
  logic                    col_last;
  logic                    row_last;

  assign elem_ext  = {{(SUM_W-ELEM_W){elem_value[ELEM_W-1]}}, elem_value};
  assign rd_sum    = sum_mem[cmd.scan_step ? scan_idx : col_pos];
  assign col_last  = (SIZE_W'(col_pos) == cols_eff - SIZE_W'(1));
  assign row_last  = (SIZE_W'(row_pos) == rows_eff - SIZE_W'(1));

  // Strictly greater keeps the lower column on equal sums
  assign take      = !picked[scan_idx] && (!has_best || (rd_sum > best_sum));
  assign final_col = take ? scan_idx : best_col;
  assign final_sum = take ? rd_sum : best_sum;

  always_comb begin
    status           = '0;
    status.elem_last = col_last && row_last;
    status.scan_last = (SIZE_W'(scan_idx) == cols_eff - SIZE_W'(1));
    status.rank_last = (SIZE_W'(rank_idx) == cols_eff - SIZE_W'(1));
  end

  // First row overwrites, so no clearing pass is needed between jobs
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum_mem[col_pos] <= (row_pos == '0) ? elem_ext : rd_sum + elem_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos  <= '0;
      col_pos  <= '0;
      scan_idx <= '0;
      rank_idx <= '0;
      picked   <= '0;
      has_best <= 1'b0;
    end else begin
      if (cfg_clear) begin
        row_pos <= '0;
        col_pos <= '0;
      end else if (cmd.load) begin
        if (col_last) begin
          col_pos <= '0;
          row_pos <= row_last ? '0 : row_pos + ROW_W'(1);
        end else begin
          col_pos <= col_pos + COL_W'(1);
        end
      end

      if (cmd.job_start) begin
        scan_idx <= '0;
        rank_idx <= '0;
        picked   <= '0;
        has_best <= 1'b0;
      end else if (cmd.scan_step) begin
        if (status.scan_last) begin
          scan_idx          <= '0;
          has_best          <= 1'b0;
          picked[final_col] <= 1'b1;
        end else begin
          scan_idx <= scan_idx + COL_W'(1);
          has_best <= has_best || take;
        end
      end

      if (cmd.emit_done) begin
        rank_idx <= rank_idx + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && take) begin
      best_col <= scan_idx;
      best_sum <= rd_sum;
    end
    if (cmd.scan_step && status.scan_last) begin
      source_column <= final_col;
      column_sum    <= final_sum;
      last_flag     <= status.rank_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_picked_count: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> ($countones(picked) == int'(rank_idx)))
    else $error("picked columns out of step with rank");

  a_fresh_pick: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_step && status.scan_last) |-> !picked[final_col])
    else $error("column ranked twice");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    SIZE_W'(col_pos) < cols_eff)
    else $error("column position beyond matrix width");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    SIZE_W'(row_pos) < rows_eff)
    else $error("row position beyond matrix height");
`endif

endmodule

// ----- rtl/core/column_sum_sorter_unit.sv -----
// ----------------------------------------------------------------------------
// column_sum_sorter_unit
// Accumulates per-column sums of a streamed matrix and emits the columns
// ranked by descending sum.
// ----------------------------------------------------------------------------
// Elements arrive row-major, one word per cycle with no gaps required, while
// one signed 20-bit sum per column accumulates (wrapping modulo 2^20). The
// matrix size comes from the rows_in_use (byte address 0) and cols_in_use
// (byte address 4) registers; 0 acts as 1 and values above 16 act as 16.
// Writing either register restarts the matrix being loaded. After the last
// element the input stalls and the unit ranks the columns by a max search:
// each rank costs one pass over the sum registers, one column per cycle,
// followed by its output word. Equal sums rank lower column first, and
// last_flag marks the final word of the job. The input stays stalled until
// the last word of the job is taken; a stalled output word holds the scan.
// ----------------------------------------------------------------------------
module column_sum_sorter_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // element input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [csort_pkg::ELEM_W-1:0]  elem_value,
  // ranked output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [csort_pkg::COL_W-1:0]          source_column,
  output logic signed [csort_pkg::SUM_W-1:0]   column_sum,
  output logic                                 last_flag,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [csort_pkg::ADDR_W-1:0]         paddr,
  input  logic [csort_pkg::DATA_W-1:0]         pwdata,
  output logic [csort_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);
  import csort_pkg::*;

  logic [SIZE_W-1:0] rows_cfg;
  logic [SIZE_W-1:0] cols_cfg;
  logic [SIZE_W-1:0] rows_eff;
  logic [SIZE_W-1:0] cols_eff;
  logic              cfg_wr;
  csort_cmd_t        cmd;
  csort_status_t     status;

  // Zero-wait-state port; word select on paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= SIZE_RESET;
      cols_cfg <= SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ROWS: rows_cfg <= pwdata[SIZE_W-1:0];
        REG_COLS: cols_cfg <= pwdata[SIZE_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROWS: prdata = DATA_W'(rows_cfg);
      REG_COLS: prdata = DATA_W'(cols_cfg);
      default:  prdata = '0;
    endcase
  end

  // Clamp at use; the raw value stays readable
  assign rows_eff = clamp_size(rows_cfg, ROWS_LIMIT);
  assign cols_eff = clamp_size(cols_cfg, COLS_LIMIT);

  csort_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  csort_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_clear     (cfg_wr),
    .rows_eff      (rows_eff),
    .cols_eff      (cols_eff),
    .elem_value    (elem_value),
    .status        (status),
    .source_column (source_column),
    .column_sum    (column_sum),
    .last_flag     (last_flag)
  );

endmodule

// ----- sim/column_sum_sorter_unit_test.sv -----
// ----------------------------------------------------------------------------
// column_sum_sorter_unit_test
// Self-checking bench for the column sum sorter: streams matrices of many
// sizes through the element port, predicts the ranked column words from its
// own per-column sums, and compares every output word field by field.
// ----------------------------------------------------------------------------
module column_sum_sorter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import csort_pkg::*;

  localparam int  ITEMS_TARGET = 360;
  localparam int  SETTLE       = 12;      // quiet cycles before a register write
  localparam int  TAIL         = 60;      // cycles watched after the last word
  localparam int  CYCLE_LIMIT  = 400000;

  // Value patterns used to fill a matrix
  localparam int VAL_FULL    = 0;
  localparam int VAL_EXTREME = 1;
  localparam int VAL_NARROW  = 2;
  localparam int VAL_COLUMN  = 3;

  localparam logic [ADDR_W-1:0] ROWS_ADDR = {REG_ROWS, 2'b00};
  localparam logic [ADDR_W-1:0] COLS_ADDR = {REG_COLS, 2'b00};

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct packed {
    logic [COL_W-1:0]        col;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } ranked_word_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  // Block ports; the inputs are all known from time zero
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  elem_t                    elem_value = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic [COL_W-1:0]         source_column;
  logic signed [SUM_W-1:0]  column_sum;
  logic                     last_flag;
  logic                     psel       = 1'b0;
  logic                     penable    = 1'b0;
  logic                     pwrite     = 1'b0;
  logic [ADDR_W-1:0]        paddr      = '0;
  logic [DATA_W-1:0]        pwdata     = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  column_sum_sorter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .elem_value   (elem_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .source_column(source_column),
    .column_sum   (column_sum),
    .last_flag    (last_flag),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // --------------------------------------------------------------------------
  // Shadow of the block: size registers, running column sums, position
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0]       rows_reg;
  logic [SIZE_W-1:0]       cols_reg;
  logic signed [SUM_W-1:0] col_acc [MAX_COLS];
  int                      row_at;
  int                      col_at;

  ranked_word_t ranked_q [$];   // ranked words still owed by the block
  elem_t        elem_q   [$];   // words waiting to be presented

  int items_pushed  = 0;
  int items_taken   = 0;
  int job_items     = 0;
  int jobs_ranked   = 0;
  int words_checked = 0;
  int abandoned     = 0;
  int errors        = 0;
  int cycle_count   = 0;
  int idle_mode     = 1;        // 0: no gaps or stalls, 1: random gaps and stalls
  int feed_gap      = 0;
  int drain_gap     = 0;

  // 0 counts as 1, anything past the maximum counts as the maximum
  function automatic int eff_size(input logic [SIZE_W-1:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void clear_sums();
    for (int i = 0; i < MAX_COLS; i++) col_acc[i] = '0;
    row_at = 0;
    col_at = 0;
  endfunction

  // Fold one accepted word into the sums; on the last word of the matrix,
  // rank the columns and queue the words the block must send.
  function automatic void take_element(input elem_t v);
    int           nr;
    int           nc;
    int           order [MAX_COLS];
    int           i;
    int           j;
    int           key;
    ranked_word_t w;
    nr = eff_size(rows_reg, MAX_ROWS);
    nc = eff_size(cols_reg, MAX_COLS);
    if (col_at >= nc || row_at >= nr) clear_sums();
    // wrap modulo 2^SUM_W after sign extension
    col_acc[col_at] = col_acc[col_at] + {{(SUM_W-ELEM_W){v[ELEM_W-1]}}, v};
    col_at++;
    if (col_at < nc) return;
    col_at = 0;
    row_at++;
    if (row_at < nr) return;
    // stable descending insertion sort: equal sums keep the lower column first
    for (i = 0; i < nc; i++) order[i] = i;
    for (i = 1; i < nc; i++) begin
      key = order[i];
      j = i;
      while (j > 0 && col_acc[order[j-1]] < col_acc[key]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    for (i = 0; i < nc; i++) begin
      w.col  = COL_W'(order[i]);
      w.sum  = col_acc[order[i]];
      w.last = (i == nc - 1);
      ranked_q.push_back(w);
    end
    jobs_ranked++;
    clear_sums();
  endfunction

  // Mostly short gaps, a few long ones, none at all in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_mode == 0 || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Element driver: present queued words, hold them while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      feed_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        // predict first so the owed words exist before the word counts as taken
        take_element(elem_value);
        items_taken++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (feed_gap > 0) begin
        feed_gap--;
        in_valid <= 1'b0;
      end else if (elem_q.size() > 0) begin
        in_valid   <= 1'b1;
        elem_value <= elem_q.pop_front();
        feed_gap   = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: stall at random, compare each accepted word
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_out
    ranked_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
      drain_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (ranked_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, got column %0d sum %0d last %0b",
                   $time, source_column, column_sum, last_flag);
          errors++;
        end else begin
          want = ranked_q.pop_front();
          if (source_column !== want.col) begin
            $display("%0t: source_column expected %0d got %0d",
                     $time, want.col, source_column);
            errors++;
          end
          if (column_sum !== want.sum) begin
            $display("%0t: column_sum (column %0d) expected %0d got %0d",
                     $time, want.col, want.sum, column_sum);
            errors++;
          end
          if (last_flag !== want.last) begin
            $display("%0t: last_flag (column %0d) expected %0b got %0b",
                     $time, want.col, want.last, last_flag);
            errors++;
          end
          words_checked++;
        end
      end
      if (drain_gap > 0) begin
        out_stall <= 1'b1;
        drain_gap--;
      end else begin
        out_stall <= 1'b0;
        drain_gap = pick_gap();
      end
    end
  end

  // Watchdog: give up well past the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words still owed", $time, ranked_q.size());
      $display("column_sum_sorter_unit: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send(input elem_t v);
    elem_q.push_back(v);
    items_pushed++;
  endtask

  // Wait until every word is taken and every ranked word has come back,
  // then let the block settle before touching its registers.
  task automatic wait_idle();
    while (!(items_taken == items_pushed && ranked_q.size() == 0)) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [SIZE_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register takes the value at this edge; any partial matrix is dropped
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (a == ROWS_ADDR) rows_reg = v;
    else cols_reg = v;
    clear_sums();
  endtask

  task automatic apb_read_check(input logic [ADDR_W-1:0] a);
    logic [DATA_W-1:0] got;
    logic [DATA_W-1:0] want;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    want = (a == ROWS_ADDR) ? DATA_W'(rows_reg) : DATA_W'(cols_reg);
    if (got !== want) begin
      $display("%0t: register at %0d expected %0d got %0d", $time, a, want, got);
      errors++;
    end
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] r, input logic [SIZE_W-1:0] c);
    wait_idle();
    apb_write(ROWS_ADDR, r);
    apb_write(COLS_ADDR, c);
    apb_read_check(ROWS_ADDR);
    apb_read_check(COLS_ADDR);
  endtask

  // Queue one whole matrix at the current size
  task automatic send_job(input int mode);
    elem_t level [MAX_COLS];
    elem_t v;
    int    nr;
    int    nc;
    int    r;
    int    c;
    nr = eff_size(rows_reg, MAX_ROWS);
    nc = eff_size(cols_reg, MAX_COLS);
    for (c = 0; c < MAX_COLS; c++) begin
      case ($urandom_range(0, 3))
        0:       level[c] = 16'sh7fff;
        1:       level[c] = 16'sh8000;
        default: level[c] = ELEM_W'($urandom_range(0, 6) - 3);
      endcase
    end
    for (r = 0; r < nr; r++) begin
      for (c = 0; c < nc; c++) begin
        case (mode)
          VAL_FULL:    v = ELEM_W'($urandom);
          VAL_EXTREME: begin
            case ($urandom_range(0, 3))
              0:       v = 16'sh7fff;
              1:       v = 16'sh8000;
              2:       v = '0;
              default: v = '1;
            endcase
          end
          VAL_NARROW:  v = ELEM_W'($urandom_range(0, 4) - 2);
          default:     v = level[c];
        endcase
        send(v);
      end
    end
    job_items += nr * nc;
  endtask

  // Draw a raw register value: mostly small, sometimes large or out of range
  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return SIZE_W'($urandom_range(1, 4));
    if (r < 85) return SIZE_W'($urandom_range(5, 16));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return SIZE_W'(16);
      2:       return '1;
      default: return SIZE_W'($urandom_range(17, 31));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : run
    elem_t        one_row [16];
    logic [SIZE_W-1:0] rr;
    logic [SIZE_W-1:0] cc;
    int           nr;
    int           nc;
    int           k;
    int           n;

    rows_reg = SIZE_RESET;
    cols_reg = SIZE_RESET;
    clear_sums();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset values read back as sixteen by sixteen
    apb_read_check(ROWS_ADDR);
    apb_read_check(COLS_ADDR);

    // Start a matrix at the reset size, then drop it with a size write
    send(16'sh1234);
    send(16'sh8000);
    send(16'sh7fff);
    abandoned++;

    // Zero rows acts as one, 31 columns acts as sixteen: one ranked row with
    // both extremes, ties at 7 and at 0, and alternating bit patterns
    one_row = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0007, 16'sh0007, 16'shffff,
                16'sh0001, 16'sh0000, 16'sh5555, 16'shaaaa, 16'sh0007, 16'sh8000,
                16'sh7fff, 16'sh0064, 16'shff9c, 16'sh0000};
    set_size('0, '1);
    for (k = 0; k < 16; k++) send(one_row[k]);
    job_items += 16;

    // Two by two with both sums equal: lower column must lead
    set_size(SIZE_W'(2), SIZE_W'(2));
    send(16'sh0005);
    send(16'shfffb);
    send(16'shfffb);
    send(16'sh0005);
    job_items += 4;

    // Sixteen rows of the extremes: the sums reach the bottom of their range and come close to the top
    set_size(SIZE_W'(16), SIZE_W'(2));
    for (k = 0; k < 16; k++) begin
      send(16'sh7fff);
      send(16'sh8000);
    end
    job_items += 32;
    send_job(VAL_FULL);

    // Random sizes, patterns and pacing; keep matrices small most of the time
    while (job_items < ITEMS_TARGET) begin
      rr = pick_size();
      cc = pick_size();
      if (eff_size(rr, MAX_ROWS) * eff_size(cc, MAX_COLS) > 64)
        cc = SIZE_W'($urandom_range(1, 4));
      set_size(rr, cc);
      idle_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(0, 9))
          0, 1:    send_job(VAL_EXTREME);
          2, 3:    send_job(VAL_NARROW);
          4:       send_job(VAL_COLUMN);
          default: send_job(VAL_FULL);
        endcase
      end
      // Now and then leave a matrix half loaded for the next size write
      nr = eff_size(rows_reg, MAX_ROWS);
      nc = eff_size(cols_reg, MAX_COLS);
      if (nr * nc > 1 && $urandom_range(0, 5) == 0) begin
        for (k = $urandom_range(1, nr * nc - 1); k > 0; k--) send(ELEM_W'($urandom));
        abandoned++;
      end
    end

    // Drain, then watch a while for stray words
    idle_mode = 1;
    while (!(items_taken == items_pushed && ranked_q.size() == 0)) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("Fed %0d words into %0d ranked matrices (%0d left half loaded).",
             items_pushed, jobs_ranked, abandoned);
    $display("Checked %0d ranked words over sizes from 1x1 to 16x16 limits.",
             words_checked);
    if (errors == 0 && ranked_q.size() == 0) begin
      $display("column_sum_sorter_unit: match");
    end else begin
      $display("column_sum_sorter_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/csort_pkg.sv
rtl/core/csort_ctrl.sv
rtl/core/csort_dp.sv
rtl/core/column_sum_sorter_unit.sv
sim/column_sum_sorter_unit_test.sv
